// ----- design/dspwm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package dspwm_pkg;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [7:0] REG_ID      = 8'd0;
  localparam logic [7:0] REG_VERSION = 8'd1;
  localparam logic [7:0] REG_EN_A    = 8'd2;
  localparam logic [7:0] REG_TEMP_A  = 8'd3;
  localparam logic [7:0] REG_WIDTH_A = 8'd4;
  localparam logic [7:0] REG_EN_B    = 8'd5;
  localparam logic [7:0] REG_TEMP_B  = 8'd6;
  localparam logic [7:0] REG_WIDTH_B = 8'd7;

  localparam logic [7:0]  ID_BYTE      = 8'h20;
  localparam logic [7:0]  VERSION_BYTE = 8'h01;
  localparam logic [7:0]  UNKNOWN_BYTE = 8'hFF;
  localparam logic [15:0] TOP_RESET    = 16'd15000;
  localparam logic [15:0] WIDTH_RESET  = 16'((600 + 2400) / 2);

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       servo_a_drive;
    logic       servo_a_level;
    logic       servo_b_drive;
    logic       servo_b_level;
  } result_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage
`default_nettype wire

// ----- design/dual_servo_pwm_register_block_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel | handshake         | beat
// in_     | in_valid/in_stall | item_t: action, reg_addr, write_data
// out_    | out_valid/out_stall | result_t: read_data, drive and level per servo
// cfg_    | cfg_valid/cfg_ready | 16-bit period_top
// a beat is registered on entry, decoded combinationally against the register map
// and the tick counter, and lands in the result register
// one beat per cycle if unstalled; the result register frees as soon as it is taken
// synchronous active-low reset restores the register map, counter and period_top
// a stalled result holds the input register, which then stalls the input side
module dual_servo_pwm_register_block_unit
  import dspwm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire item_t       in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output result_t          out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  stage_ctl_t  ctl;
  item_t       item;
  result_t     result_nxt;
  result_t     out_data_r;
  logic        out_valid_r;
  logic        out_free;
  logic [15:0] period_top_r;

  assign out_free = !out_valid_r || !out_stall;

  dspwm_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (out_free),
    .ctl      (ctl),
    .item     (item)
  );

  dspwm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (ctl.advance),
    .item       (item),
    .period_top (period_top_r),
    .result     (result_nxt)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      period_top_r <= TOP_RESET;
    end else begin
      if (out_free) begin
        out_valid_r <= ctl.valid;
      end
      if (cfg_valid && cfg_ready) begin
        period_top_r <= cfg_data;
      end
    end
    if (ctl.advance) begin
      out_data_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_spurious_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (!ctl.valid && !out_valid_r) |=> !out_valid_r)
    else $error("result beat appeared with nothing in flight");

  a_blocked_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.valid && !out_free) |=> ctl.valid)
    else $error("input beat dropped while result stalled");

  a_read_data_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.advance && item.action != ACT_READ) |=> (out_data_r.read_data == 8'd0))
    else $error("non-read beat returned read data");

endmodule
`default_nettype wire

// ----- design/dspwm_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dspwm_in_stage
  import dspwm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire item_t in_data,
  input  wire logic  advance,
  output stage_ctl_t ctl,
  output item_t      item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  assign in_stall  = valid_r && !advance;
  assign take      = in_valid && !in_stall;
  assign valid_nxt = take || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (take) begin
      item_r <= in_data;
    end
  end

  assign ctl.valid   = valid_r;
  assign ctl.advance = valid_r && advance;
  assign item        = item_r;

endmodule
`default_nettype wire

// ----- design/dspwm_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dspwm_core
  import dspwm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,
  input  wire item_t       item,
  input  wire logic [15:0] period_top,
  output result_t          result
);

  logic [15:0] tick_r, tick_nxt;
  logic [15:0] buf_a_r, buf_a_nxt;
  logic [15:0] buf_b_r, buf_b_nxt;
  logic [15:0] cmp_a_r, cmp_a_nxt;
  logic [15:0] cmp_b_r, cmp_b_nxt;
  logic [7:0]  temp_a_r, temp_a_nxt;
  logic [7:0]  temp_b_r, temp_b_nxt;
  logic        en_a_r, en_a_nxt;
  logic        en_b_r, en_b_nxt;
  logic [7:0]  rd;

  always_comb begin
    tick_nxt   = tick_r;
    buf_a_nxt  = buf_a_r;
    buf_b_nxt  = buf_b_r;
    cmp_a_nxt  = cmp_a_r;
    cmp_b_nxt  = cmp_b_r;
    temp_a_nxt = temp_a_r;
    temp_b_nxt = temp_b_r;
    en_a_nxt   = en_a_r;
    en_b_nxt   = en_b_r;
    rd         = '0;
    case (action_t'(item.action))
      ACT_READ: begin
        case (item.reg_addr)
          REG_ID:      rd = ID_BYTE;
          REG_VERSION: rd = VERSION_BYTE;
          REG_EN_A:    rd = {7'd0, en_a_r};
          REG_TEMP_A:  rd = temp_a_r;
          REG_WIDTH_A: begin
            temp_a_nxt = buf_a_r[15:8];
            rd         = buf_a_r[7:0];
          end
          REG_EN_B:    rd = {7'd0, en_b_r};
          REG_TEMP_B:  rd = temp_b_r;
          REG_WIDTH_B: begin
            temp_b_nxt = buf_b_r[15:8];
            rd         = buf_b_r[7:0];
          end
          default:     rd = UNKNOWN_BYTE;
        endcase
      end
      ACT_WRITE: begin
        case (item.reg_addr)
          REG_EN_A:    en_a_nxt   = |item.write_data;
          REG_TEMP_A:  temp_a_nxt = item.write_data;
          REG_WIDTH_A: buf_a_nxt  = {temp_a_r, item.write_data};
          REG_EN_B:    en_b_nxt   = |item.write_data;
          REG_TEMP_B:  temp_b_nxt = item.write_data;
          REG_WIDTH_B: buf_b_nxt  = {temp_b_r, item.write_data};
          default: ;
        endcase
      end
      ACT_TICK: begin
        if (tick_r >= period_top) begin
          tick_nxt  = '0;
          cmp_a_nxt = buf_a_r;
          cmp_b_nxt = buf_b_r;
        end else begin
          tick_nxt = tick_r + 16'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      buf_a_r  <= WIDTH_RESET;
      buf_b_r  <= WIDTH_RESET;
      cmp_a_r  <= WIDTH_RESET;
      cmp_b_r  <= WIDTH_RESET;
      temp_a_r <= '0;
      temp_b_r <= '0;
      en_a_r   <= 1'b0;
      en_b_r   <= 1'b0;
    end else if (fire) begin
      tick_r   <= tick_nxt;
      buf_a_r  <= buf_a_nxt;
      buf_b_r  <= buf_b_nxt;
      cmp_a_r  <= cmp_a_nxt;
      cmp_b_r  <= cmp_b_nxt;
      temp_a_r <= temp_a_nxt;
      temp_b_r <= temp_b_nxt;
      en_a_r   <= en_a_nxt;
      en_b_r   <= en_b_nxt;
    end
  end

  assign result.read_data     = rd;
  assign result.servo_a_drive = en_a_nxt;
  assign result.servo_a_level = tick_nxt <= cmp_a_nxt;
  assign result.servo_b_drive = en_b_nxt;
  assign result.servo_b_level = tick_nxt <= cmp_b_nxt;

endmodule
`default_nettype wire
